// ----- rtl/core/mfau_pkg.sv -----
// Shared constants and types for the motor feedback angle unwrap block.
`default_nettype none

package mfau_pkg;

  localparam int unsigned MOTOR_COUNT = 4;
  localparam int unsigned MOTOR_IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam int unsigned ID_W    = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [ID_W-1:0] BASE_ID_RESET = 11'h201;

  localparam logic signed [ANGLE_W-1:0] TURN_COUNTS = 16'sd8192;
  localparam logic signed [ANGLE_W-1:0] WRAP_LIMIT  = 16'sd7500;

  typedef struct packed {
    logic                   hit;
    logic [MOTOR_IDX_W-1:0] idx;
  } match_t;

endpackage

`default_nettype wire

// ----- rtl/core/mfau_match.sv -----
// Frame identifier window compare that selects the motor.
`default_nettype none

module mfau_match
  import mfau_pkg::*;
(
  input  logic [ID_W-1:0] frame_id_i,
  input  logic [ID_W-1:0] base_i,
  output match_t          match_o
);

  logic [ID_W:0] diff;

  assign diff = {1'b0, frame_id_i} - {1'b0, base_i};

  always_comb begin
    match_o.hit = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(MOTOR_COUNT));
    match_o.idx = diff[MOTOR_IDX_W-1:0];
  end

endmodule

`default_nettype wire

// ----- rtl/core/mfau_track.sv -----
// Per-motor angle history, wrap-corrected step and multi-turn total.
`default_nettype none

module mfau_track
  import mfau_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic [MOTOR_IDX_W-1:0]      idx_i,
  input  logic [ANGLE_W-1:0]          angle_i,
  output logic signed [ANGLE_W-1:0]   step_o,
  output logic signed [TOTAL_W-1:0]   total_o
);

  logic [ANGLE_W-1:0]      prev_q [MOTOR_COUNT];
  logic [TOTAL_W-1:0]      acc_q  [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0]  seen_q;

  logic signed [ANGLE_W-1:0] raw;
  logic signed [ANGLE_W-1:0] fix;

  assign raw = signed'(angle_i - prev_q[idx_i]);

  always_comb begin
    if (raw > WRAP_LIMIT) begin
      fix = raw - TURN_COUNTS;
    end else if (raw < -WRAP_LIMIT) begin
      fix = raw + TURN_COUNTS;
    end else begin
      fix = raw;
    end
  end

  assign step_o  = seen_q[idx_i] ? fix : '0;
  assign total_o = signed'(acc_q[idx_i] + {{(TOTAL_W-ANGLE_W){step_o[ANGLE_W-1]}}, step_o});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        prev_q[i] <= '0;
        acc_q[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        if (upd_i && (idx_i == MOTOR_IDX_W'(i))) begin
          seen_q[i] <= 1'b1;
          prev_q[i] <= angle_i;
          acc_q[i]  <= unsigned'(total_o);
        end
      end
    end
  end

  a_first_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_i && !seen_q[idx_i]) |-> (step_o == '0))
    else $error("first beat of a motor produced a nonzero step");

  a_seen_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |=> seen_q[$past(idx_i)])
    else $error("seen flag not set after an update");

  a_prev_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i |=> (prev_q[$past(idx_i)] == $past(angle_i)))
    else $error("previous angle not stored");

endmodule

`default_nettype wire

// ----- rtl/core/motor_feedback_angle_unwrap.sv -----
// Top level of the motor feedback angle unwrap block.
//
// Input channel: in_valid_i/in_ready_o carry one received bus frame per beat,
// an 11-bit identifier and seven payload bytes. A frame whose identifier lies
// in base_frame_id to base_frame_id+MOTOR_COUNT-1 selects one motor and gives
// one result beat; any other frame is consumed and gives none.
// Output channel: out_valid_o/out_ready_i carry the decoded fields, the
// wrap-corrected angle step and the motor's 32-bit multi-turn total.
// The base identifier is written through base_frame_id_we_i; the user must
// write it only while idle, as the block itself does not enforce it. A frame
// goes from input beat to result beat through an input register and a
// result register, with the decode, step and total logic between them. One
// frame is accepted every cycle while results are taken. When the receiver
// stalls, the result register holds and one more frame waits in the input
// register before in_ready_o drops. Reset clears the per-motor angles,
// totals and first-frame flags and sets the base identifier to 0x201.
`default_nettype none

module motor_feedback_angle_unwrap
  import mfau_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      base_frame_id_we_i,
  input  logic [ID_W-1:0]           base_frame_id_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ID_W-1:0]           frame_id_i,
  input  logic [BYTE_W-1:0]         byte0_i,
  input  logic [BYTE_W-1:0]         byte1_i,
  input  logic [BYTE_W-1:0]         byte2_i,
  input  logic [BYTE_W-1:0]         byte3_i,
  input  logic [BYTE_W-1:0]         byte4_i,
  input  logic [BYTE_W-1:0]         byte5_i,
  input  logic [BYTE_W-1:0]         byte6_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [MOTOR_IDX_W-1:0]    motor_index_o,
  output logic [ANGLE_W-1:0]        raw_angle_o,
  output logic signed [15:0]        speed_rpm_o,
  output logic signed [15:0]        current_raw_o,
  output logic [BYTE_W-1:0]         temperature_o,
  output logic signed [ANGLE_W-1:0] angle_step_o,
  output logic signed [TOTAL_W-1:0] total_angle_o
);

  logic [ID_W-1:0]   base_q;

  logic              s1_valid_q;
  logic [ID_W-1:0]   s1_id_q;
  logic [BYTE_W-1:0] s1_byte_q [7];

  logic              out_valid_q;
  logic              out_valid_d;

  match_t                    match;
  logic                      s1_adv;
  logic                      upd;
  logic [ANGLE_W-1:0]        angle;
  logic signed [ANGLE_W-1:0] step;
  logic signed [TOTAL_W-1:0] total;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign upd        = s1_adv && match.hit;
  assign angle      = {s1_byte_q[0], s1_byte_q[1]};

  mfau_match u_match (
    .frame_id_i (s1_id_q),
    .base_i     (base_q),
    .match_o    (match)
  );

  mfau_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .idx_i   (match.idx),
    .angle_i (angle),
    .step_o  (step),
    .total_o (total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_ID_RESET;
    end else if (base_frame_id_we_i) begin
      base_q <= base_frame_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_id_q      <= frame_id_i;
      s1_byte_q[0] <= byte0_i;
      s1_byte_q[1] <= byte1_i;
      s1_byte_q[2] <= byte2_i;
      s1_byte_q[3] <= byte3_i;
      s1_byte_q[4] <= byte4_i;
      s1_byte_q[5] <= byte5_i;
      s1_byte_q[6] <= byte6_i;
    end
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_d = match.hit;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      motor_index_o <= match.idx;
      raw_angle_o   <= angle;
      speed_rpm_o   <= signed'({s1_byte_q[2], s1_byte_q[3]});
      current_raw_o <= signed'({s1_byte_q[4], s1_byte_q[5]});
      temperature_o <= s1_byte_q[6];
      angle_step_o  <= step;
      total_angle_o <= total;
    end
  end

  assign out_valid_o = out_valid_q;

  a_ready_low_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while a stage was free");

  a_result_from_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && match.hit))
    else $error("result beat without a matching frame");

  a_step_matches_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd && (step == '0)) |-> (unsigned'(total) == u_track.acc_q[match.idx]))
    else $error("zero step changed the total");

endmodule

`default_nettype wire

// ----- verif/tb_motor_feedback_angle_unwrap.sv -----
// Self-checking testbench for the motor feedback angle unwrap block.
module tb_motor_feedback_angle_unwrap;
  timeunit 1ns;
  timeprecision 1ps;

  import mfau_pkg::*;

  localparam int CYCLE_LIMIT = 50000;
  localparam int BURST_FRAMES = 40;

  typedef struct packed {
    logic [ID_W-1:0]             id;
    logic [0:6][BYTE_W-1:0]      payload;
  } frame_t;

  typedef struct packed {
    logic [MOTOR_IDX_W-1:0]      motor;
    logic [ANGLE_W-1:0]          raw_angle;
    logic [15:0]                 speed;
    logic [15:0]                 current;
    logic [BYTE_W-1:0]           temperature;
    logic [ANGLE_W-1:0]          step;
    logic [TOTAL_W-1:0]          total;
  } feedback_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              cfg_we = 1'b0;
  logic [ID_W-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  frame_t            tx_frame = '0;
  logic              out_ready = 1'b0;

  logic                      in_ready;
  logic                      out_valid;
  logic [MOTOR_IDX_W-1:0]    motor_index;
  logic [ANGLE_W-1:0]        raw_angle;
  logic signed [15:0]        speed_rpm;
  logic signed [15:0]        current_raw;
  logic [BYTE_W-1:0]         temperature;
  logic signed [ANGLE_W-1:0] angle_step;
  logic signed [TOTAL_W-1:0] total_angle;

  frame_t    frame_queue[$];
  feedback_t feedback_queue[$];

  logic [ID_W-1:0]    base_id_model;
  logic [ANGLE_W-1:0] prev_angle_model [MOTOR_COUNT];
  logic [TOTAL_W-1:0] total_model [MOTOR_COUNT];
  logic               seen_model [MOTOR_COUNT];
  logic [ANGLE_W-1:0] gen_angle [MOTOR_COUNT];

  int send_idle_pct = 10;
  int recv_idle_pct = 10;
  int cycle_count = 0;
  int mismatch_count = 0;
  int frames_accepted = 0;
  int results_checked = 0;
  int first_frames = 0;
  int forward_wraps = 0;
  int backward_wraps = 0;
  int total_overflows = 0;
  int base_settings = 1;

  always #5 clk_i = ~clk_i;

  motor_feedback_angle_unwrap DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .base_frame_id_we_i (cfg_we),
    .base_frame_id_i    (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .frame_id_i         (tx_frame.id),
    .byte0_i            (tx_frame.payload[0]),
    .byte1_i            (tx_frame.payload[1]),
    .byte2_i            (tx_frame.payload[2]),
    .byte3_i            (tx_frame.payload[3]),
    .byte4_i            (tx_frame.payload[4]),
    .byte5_i            (tx_frame.payload[5]),
    .byte6_i            (tx_frame.payload[6]),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .motor_index_o      (motor_index),
    .raw_angle_o        (raw_angle),
    .speed_rpm_o        (speed_rpm),
    .current_raw_o      (current_raw),
    .temperature_o      (temperature),
    .angle_step_o       (angle_step),
    .total_angle_o      (total_angle)
  );

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 20) begin
      $display("Mismatch at cycle %0d: %s got %h, expected %h", cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic unwrap_frame(frame_t f);
    logic [ID_W-1:0]        offset;
    logic [MOTOR_IDX_W-1:0] m;
    logic [ANGLE_W-1:0]     angle;
    logic signed [15:0]     raw_step;
    logic [TOTAL_W-1:0]     old_total;
    int                     step;
    feedback_t              fb;
    if (f.id < base_id_model) return;
    offset = f.id - base_id_model;
    if (offset >= MOTOR_COUNT) return;
    m = offset[MOTOR_IDX_W-1:0];
    angle = {f.payload[0], f.payload[1]};
    raw_step = angle - prev_angle_model[m];
    step = raw_step;
    if (!seen_model[m]) begin
      step = 0;
      first_frames++;
    end else if (step > int'(WRAP_LIMIT)) begin
      step -= int'(TURN_COUNTS);
      backward_wraps++;
    end else if (step < -int'(WRAP_LIMIT)) begin
      step += int'(TURN_COUNTS);
      forward_wraps++;
    end
    seen_model[m] = 1'b1;
    prev_angle_model[m] = angle;
    old_total = total_model[m];
    total_model[m] = old_total + 32'(step);
    if (old_total[31] == step[31] && total_model[m][31] != old_total[31]) begin
      total_overflows++;
    end
    fb.motor = m;
    fb.raw_angle = angle;
    fb.speed = {f.payload[2], f.payload[3]};
    fb.current = {f.payload[4], f.payload[5]};
    fb.temperature = f.payload[6];
    fb.step = 16'(step);
    fb.total = total_model[m];
    feedback_queue.push_back(fb);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_frame <= '0;
    end else begin
      if (in_valid && in_ready) begin
        unwrap_frame(tx_frame);
        frames_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (frame_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          tx_frame <= frame_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    feedback_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (feedback_queue.size() == 0) begin
          report_mismatch("result beat with nothing expected, raw_angle", raw_angle, '0);
        end else begin
          want = feedback_queue.pop_front();
          if (motor_index !== want.motor)
            report_mismatch("motor_index", motor_index, want.motor);
          if (raw_angle !== want.raw_angle)
            report_mismatch("raw_angle", raw_angle, want.raw_angle);
          if (speed_rpm !== want.speed)
            report_mismatch("speed_rpm", speed_rpm, want.speed);
          if (current_raw !== want.current)
            report_mismatch("current_raw", current_raw, want.current);
          if (temperature !== want.temperature)
            report_mismatch("temperature", temperature, want.temperature);
          if (angle_step !== want.step)
            report_mismatch("angle_step", angle_step, want.step);
          if (total_angle !== want.total)
            report_mismatch("total_angle", total_angle, want.total);
          results_checked++;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, feedback_queue.size());
      $display("[motor_feedback_angle_unwrap] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (frame_queue.size() != 0 || in_valid || feedback_queue.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_base_id(logic [ID_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    base_id_model = value;
    base_settings++;
    @(negedge clk_i);
  endtask

  task automatic queue_frame(logic [ID_W-1:0] id, logic [15:0] angle, logic [15:0] speed,
                             logic [15:0] current, logic [7:0] temp);
    frame_t f;
    f.id = id;
    f.payload = {angle, speed, current, temp};
    frame_queue.push_back(f);
  endtask

  task automatic queue_motor(int m, logic [15:0] angle, logic [15:0] speed,
                             logic [15:0] current, logic [7:0] temp);
    gen_angle[m] = angle;
    queue_frame(11'(base_id_model + m), angle, speed, current, temp);
  endtask

  function automatic logic [15:0] pick_delta();
    int d;
    case ($urandom_range(0, 7))
      0, 1, 2: d = int'($urandom_range(0, 400)) - 200;
      3:       d = 7498 + int'($urandom_range(0, 5));
      4:       d = -(7498 + int'($urandom_range(0, 5)));
      5:       d = int'($urandom);
      6:       d = (8182 + int'($urandom_range(0, 20))) * ($urandom_range(0, 1) ? 1 : -1);
      default: d = (32760 + int'($urandom_range(0, 15))) * ($urandom_range(0, 1) ? 1 : -1);
    endcase
    return 16'(d);
  endfunction

  task automatic queue_random(int count);
    int m;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        m = $urandom_range(0, MOTOR_COUNT - 1);
        queue_motor(m, gen_angle[m] + pick_delta(), 16'($urandom), 16'($urandom),
                    8'($urandom));
      end else begin
        queue_frame(11'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    8'($urandom));
      end
    end
  endtask

  initial begin
    logic [15:0] burst_delta;
    base_id_model = BASE_ID_RESET;
    for (int i = 0; i < MOTOR_COUNT; i++) begin
      prev_angle_model[i] = '0;
      total_model[i] = '0;
      seen_model[i] = 1'b0;
      gen_angle[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    queue_frame(base_id_model - 11'd1, 16'h1234, 16'h0001, 16'h0002, 8'h03);
    queue_frame(base_id_model + 11'(MOTOR_COUNT), 16'h4321, 16'h0004, 16'h0005, 8'h06);
    queue_motor(0, 16'h1234, 16'h7FFF, 16'h8000, 8'h00);
    queue_motor(0, gen_angle[0] + 16'd100, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(0, gen_angle[0] - 16'd7500, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(0, gen_angle[0] - 16'd7501, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(0, gen_angle[0] + 16'd7500, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(0, gen_angle[0] + 16'd7501, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(1, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF);
    queue_motor(1, 16'h0000, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(1, 16'h8000, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(1, 16'hFFFF, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_motor(2, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    queue_motor(3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    queue_motor(2, 16'h0000, 16'($urandom), 16'($urandom), 8'($urandom));
    queue_frame(11'h000, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    queue_frame(11'h7FF, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    wait_idle();

    queue_random(120);
    wait_idle();
    write_base_id(11'h000);
    queue_random(120);
    wait_idle();
    write_base_id(11'h7FF);
    queue_random(100);
    wait_idle();
    write_base_id(11'h7FD);
    queue_random(100);
    wait_idle();
    write_base_id(11'h7FC);
    queue_random(100);
    wait_idle();
    write_base_id(11'($urandom_range(1, 2043)));
    queue_random(120);
    wait_idle();

    // Feed one motor its largest steps back to back with no idle cycles.
    write_base_id(BASE_ID_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    burst_delta = total_model[3][31] ? 16'h8000 : 16'h7FFF;
    for (int i = 0; i < BURST_FRAMES; i++) begin
      queue_motor(3, gen_angle[3] + burst_delta, 16'($urandom), 16'($urandom),
                  8'($urandom));
    end
    wait_idle();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    queue_random(40);
    wait_idle();
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d frames accepted, %0d results checked, %0d base identifier settings.",
             frames_accepted, results_checked, base_settings);
    $display("Summary: %0d first frames, %0d forward and %0d backward wraps, %0d total overflows.",
             first_frames, forward_wraps, backward_wraps, total_overflows);
    if (mismatch_count == 0) begin
      $display("[motor_feedback_angle_unwrap] OK");
    end else begin
      $display("[motor_feedback_angle_unwrap] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mfau_pkg.sv
rtl/core/mfau_match.sv
rtl/core/mfau_track.sv
rtl/core/motor_feedback_angle_unwrap.sv
verif/tb_motor_feedback_angle_unwrap.sv
